@@ sv/rvr_pkg.sv @@
package rvr_pkg;

   // volume store bounds
   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;
   localparam int MAX_DEPTH  = 64;
   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);
   localparam int ZW = $clog2(MAX_DEPTH);
   localparam int BANK_AW = (XW - 1) + (YW - 1) + (ZW - 1);
   localparam int BANK_DEPTH = 2 ** BANK_AW;

   // field widths
   localparam int COORD_W = 6;
   localparam int VOX_W   = 8;
   localparam int ROW_W   = 64;
   localparam int DIM_W   = 7;
   localparam int CSR_IDX_W = 3;
   localparam int T_W     = 28;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_X      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_Y      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_Z      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VOL_WIDTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VOL_HEIGHT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_VOL_DEPTH  = 3'd5;

   // register reset values
   localparam logic [ROW_W-1:0] ROW_X_RST = 64'd16384;
   localparam logic [ROW_W-1:0] ROW_Y_RST = 64'd1073741824;
   localparam logic [ROW_W-1:0] ROW_Z_RST = 64'd70368744177664;
   localparam logic [DIM_W-1:0] DIM_RST   = 7'd64;

   // function codes
   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   typedef struct packed {
      logic               valid;
      logic               sample;
      logic [COORD_W-1:0] cx;
      logic [COORD_W-1:0] cy;
      logic [COORD_W-1:0] cz;
      logic [VOX_W-1:0]   vin;
   } item_type;

   typedef struct packed {
      logic               valid;
      logic               sample;
      logic [COORD_W-1:0] cx;
      logic [COORD_W-1:0] cy;
      logic [COORD_W-1:0] cz;
      logic [VOX_W-1:0]   vin;
      logic signed [T_W-1:0] tx;
      logic signed [T_W-1:0] ty;
      logic signed [T_W-1:0] tz;
   } tpos_type;

   typedef struct packed {
      logic       valid;
      logic       outside;
      logic       xp;
      logic       yp;
      logic       zp;
      logic [7:0] fx;
      logic [7:0] fy;
      logic [7:0] fz;
   } rd_type;

endpackage

@@ sv/rvr_req_if.sv @@
interface rvr_req_if;
   logic                          valid;
   logic                          ready;
   logic                          func;
   logic [rvr_pkg::COORD_W-1:0]   coord_x;
   logic [rvr_pkg::COORD_W-1:0]   coord_y;
   logic [rvr_pkg::COORD_W-1:0]   coord_z;
   logic [rvr_pkg::VOX_W-1:0]     voxel_in;

   modport source (output valid, func, coord_x, coord_y, coord_z, voxel_in, input ready);
   modport sink   (input valid, func, coord_x, coord_y, coord_z, voxel_in, output ready);
endinterface

@@ sv/rvr_rsp_if.sv @@
interface rvr_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [rvr_pkg::VOX_W-1:0] voxel_out;

   modport source (output valid, voxel_out, input ready);
   modport sink   (input valid, voxel_out, output ready);
endinterface

@@ sv/rvr_xform.sv @@
module rvr_xform (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  rvr_pkg::item_type                    item,
   input  logic [2:0][rvr_pkg::ROW_W-1:0]       rows,
   output rvr_pkg::tpos_type                    tpos
);

   rvr_pkg::item_type item_ff, item2_ff;
   logic signed [2:0][2:0][23:0] prod_ff, prod_in;
   logic signed [2:0][15:0]      trans_ff, trans_in;
   rvr_pkg::tpos_type            tpos_ff, tpos_in;
   logic [2:0][6:0]              pc;

   // centred coordinates in q.1
   assign pc[0] = {item_ff.cx, 1'b1};
   assign pc[1] = {item_ff.cy, 1'b1};
   assign pc[2] = {item_ff.cz, 1'b1};

   // one product per coefficient
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[r][c] = $signed(rows[r][16*c +: 16]) * $signed({1'b0, pc[c]});
         end
         trans_in[r] = $signed(rows[r][63:48]);
      end
   end

   // row sums in q.15
   always_comb begin
      logic signed [2:0][rvr_pkg::T_W-1:0] t;
      for (int r = 0; r < 3; r++) begin
         t[r] = {{4{prod_ff[r][0][23]}}, prod_ff[r][0]}
              + {{4{prod_ff[r][1][23]}}, prod_ff[r][1]}
              + {{4{prod_ff[r][2][23]}}, prod_ff[r][2]}
              + {{2{trans_ff[r][15]}}, trans_ff[r], 10'd0};
      end
      tpos_in.valid  = item2_ff.valid;
      tpos_in.sample = item2_ff.sample;
      tpos_in.cx     = item2_ff.cx;
      tpos_in.cy     = item2_ff.cy;
      tpos_in.cz     = item2_ff.cz;
      tpos_in.vin    = item2_ff.vin;
      tpos_in.tx     = t[0];
      tpos_in.ty     = t[1];
      tpos_in.tz     = t[2];
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid  <= 1'b0;
         item2_ff.valid <= 1'b0;
         tpos_ff.valid  <= 1'b0;
      end else if (en) begin
         item_ff  <= item;
         item2_ff <= item_ff;
         prod_ff  <= prod_in;
         trans_ff <= trans_in;
         tpos_ff  <= tpos_in;
      end
   end

   assign tpos = tpos_ff;

endmodule

@@ sv/rvr_volume.sv @@
module rvr_volume (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  rvr_pkg::tpos_type                     tpos,
   input  logic [2:0][rvr_pkg::DIM_W-1:0]        dims,
   output rvr_pkg::rd_type                       rd,
   output logic [7:0][rvr_pkg::VOX_W-1:0]        rdata
);

   localparam int XB = rvr_pkg::XW - 1;
   localparam int YB = rvr_pkg::YW - 1;
   localparam int ZB = rvr_pkg::ZW - 1;

   logic signed [12:0] x0, y0, z0;
   logic signed [13:0] wl, hl, dl;
   logic               outside;
   logic [1:0][XB-1:0] xi;
   logic [1:0][YB-1:0] yi;
   logic [1:0][ZB-1:0] zi;
   logic [7:0][rvr_pkg::BANK_AW-1:0] raddr;
   logic [rvr_pkg::BANK_AW-1:0]      waddr;
   logic [7:0]                       we;
   logic                             in_store;
   rvr_pkg::rd_type                  rd_ff, rd_in;

   // floor and range check
   assign x0 = tpos.tx[rvr_pkg::T_W-1:15];
   assign y0 = tpos.ty[rvr_pkg::T_W-1:15];
   assign z0 = tpos.tz[rvr_pkg::T_W-1:15];

   always_comb begin
      wl = (int'(dims[0]) > rvr_pkg::MAX_WIDTH)  ? 14'(rvr_pkg::MAX_WIDTH)
                                                 : $signed({7'd0, dims[0]});
      hl = (int'(dims[1]) > rvr_pkg::MAX_HEIGHT) ? 14'(rvr_pkg::MAX_HEIGHT)
                                                 : $signed({7'd0, dims[1]});
      dl = (int'(dims[2]) > rvr_pkg::MAX_DEPTH)  ? 14'(rvr_pkg::MAX_DEPTH)
                                                 : $signed({7'd0, dims[2]});
      outside = (x0 < 0) || (14'(x0) + 14'sd1 >= wl)
             || (y0 < 0) || (14'(y0) + 14'sd1 >= hl)
             || (z0 < 0) || (14'(z0) + 14'sd1 >= dl);
   end

   // per-bank coordinates by parity
   always_comb begin
      logic [rvr_pkg::XW:0] xs;
      logic [rvr_pkg::YW:0] ys;
      logic [rvr_pkg::ZW:0] zs;
      for (int b = 0; b < 2; b++) begin
         xs = {1'b0, x0[rvr_pkg::XW-1:0]} + (rvr_pkg::XW+1)'(1'(b) ^ x0[0]);
         ys = {1'b0, y0[rvr_pkg::YW-1:0]} + (rvr_pkg::YW+1)'(1'(b) ^ y0[0]);
         zs = {1'b0, z0[rvr_pkg::ZW-1:0]} + (rvr_pkg::ZW+1)'(1'(b) ^ z0[0]);
         xi[b] = xs[rvr_pkg::XW-1:1];
         yi[b] = ys[rvr_pkg::YW-1:1];
         zi[b] = zs[rvr_pkg::ZW-1:1];
      end
      for (int k = 0; k < 8; k++) begin
         raddr[k] = {zi[k[2]], yi[k[1]], xi[k[0]]};
      end
   end

   // load write port
   always_comb begin
      in_store = (int'(tpos.cx) < rvr_pkg::MAX_WIDTH) && (int'(tpos.cy) < rvr_pkg::MAX_HEIGHT)
              && (int'(tpos.cz) < rvr_pkg::MAX_DEPTH);
      waddr = {tpos.cz[ZB:1], tpos.cy[YB:1], tpos.cx[XB:1]};
      for (int k = 0; k < 8; k++) begin
         we[k] = tpos.valid && !tpos.sample && in_store
              && (3'(k) == {tpos.cz[0], tpos.cy[0], tpos.cx[0]});
      end
   end

   // eight parity banks
   for (genvar g = 0; g < 8; g++) begin : g_bank
      logic [rvr_pkg::VOX_W-1:0] mem [rvr_pkg::BANK_DEPTH];
      logic [rvr_pkg::VOX_W-1:0] q_ff;
      always_ff @(posedge clock) begin
         if (en) begin
            if (we[g]) begin
               mem[waddr] <= tpos.vin;
            end
            q_ff <= mem[raddr[g]];
         end
      end
      assign rdata[g] = q_ff;
   end

   // control carried with the read
   always_comb begin
      rd_in.valid   = tpos.valid && tpos.sample;
      rd_in.outside = outside;
      rd_in.xp      = x0[0];
      rd_in.yp      = y0[0];
      rd_in.zp      = z0[0];
      rd_in.fx      = tpos.tx[14:7];
      rd_in.fy      = tpos.ty[14:7];
      rd_in.fz      = tpos.tz[14:7];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff.valid <= 1'b0;
      end else if (en) begin
         rd_ff <= rd_in;
      end
   end

   assign rd = rd_ff;

endmodule

@@ sv/rvr_blend.sv @@
module rvr_blend (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  rvr_pkg::rd_type                 rd,
   input  logic [7:0][rvr_pkg::VOX_W-1:0]  rdata,
   output logic                            out_valid,
   output logic [rvr_pkg::VOX_W-1:0]       out_voxel
);

   rvr_pkg::rd_type  c1_ff, c2_ff;
   logic             v3_ff, o3_ff;
   logic [3:0][16:0] px_ff, px_in;
   logic [1:0][24:0] py_ff, py_in;
   logic [7:0]       res_ff, res_in;

   // blend along x, four corner pairs
   always_comb begin
      logic [8:0] wf, wn;
      logic [2:0] b0, b1;
      wf = {1'b0, rd.fx};
      wn = 9'd256 - wf;
      for (int k = 0; k < 4; k++) begin
         b0 = {1'(k >> 1) ^ rd.zp, 1'(k) ^ rd.yp, rd.xp};
         b1 = {1'(k >> 1) ^ rd.zp, 1'(k) ^ rd.yp, !rd.xp};
         px_in[k] = 17'(rdata[b0] * wn) + 17'(rdata[b1] * wf);
      end
   end

   // blend along y
   always_comb begin
      logic [8:0] wf, wn;
      wf = {1'b0, c1_ff.fy};
      wn = 9'd256 - wf;
      for (int z = 0; z < 2; z++) begin
         py_in[z] = 25'(px_ff[2*z] * wn) + 25'(px_ff[2*z+1] * wf);
      end
   end

   // blend along z and round half up
   always_comb begin
      logic [8:0]  wf, wn;
      logic [32:0] s;
      wf = {1'b0, c2_ff.fz};
      wn = 9'd256 - wf;
      s = 33'(py_ff[0] * wn) + 33'(py_ff[1] * wf) + 33'd8388608;
      res_in = c2_ff.outside ? 8'd0 : s[31:24];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff.valid <= 1'b0;
         c2_ff.valid <= 1'b0;
         v3_ff       <= 1'b0;
      end else if (en) begin
         c1_ff  <= rd;
         c2_ff  <= c1_ff;
         v3_ff  <= c2_ff.valid;
         px_ff  <= px_in;
         py_ff  <= py_in;
         res_ff <= res_in;
         o3_ff  <= c2_ff.outside;
      end
   end

   assign out_valid = v3_ff;
   assign out_voxel = (o3_ff ? 8'd0 : res_ff);

endmodule

@@ sv/rigid_volume_resample_trilinear_top.sv @@
// a sample item's result passes the transform, volume read and blend register stages
// throughput: one item per cycle unless stalled; eight parity banks read all corners together
// the pipeline advances as a whole; it holds only while a result waits at the output
// reset (synchronous) clears all valid bits and loads the register reset values
// the volume store has no reset: voxels read undefined until loaded
module rigid_volume_resample_trilinear_top (
   input  logic                              clock,
   input  logic                              reset,
   rvr_req_if.sink                           req_chan,
   rvr_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [rvr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rvr_pkg::ROW_W-1:0]         csr_data
);

   logic [2:0][rvr_pkg::ROW_W-1:0] rows_ff;
   logic [2:0][rvr_pkg::DIM_W-1:0] dims_ff;
   logic                           en;
   rvr_pkg::item_type              item;
   rvr_pkg::tpos_type              tpos;
   rvr_pkg::rd_type                rd;
   logic [7:0][rvr_pkg::VOX_W-1:0] rdata;
   logic                           out_valid;
   logic [rvr_pkg::VOX_W-1:0]      out_voxel;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff[0] <= rvr_pkg::ROW_X_RST;
         rows_ff[1] <= rvr_pkg::ROW_Y_RST;
         rows_ff[2] <= rvr_pkg::ROW_Z_RST;
         dims_ff    <= {3{rvr_pkg::DIM_RST}};
      end else if (csr_we) begin
         unique case (csr_index)
            rvr_pkg::CSR_ROW_X:      rows_ff[0] <= csr_data;
            rvr_pkg::CSR_ROW_Y:      rows_ff[1] <= csr_data;
            rvr_pkg::CSR_ROW_Z:      rows_ff[2] <= csr_data;
            rvr_pkg::CSR_VOL_WIDTH:  dims_ff[0] <= csr_data[rvr_pkg::DIM_W-1:0];
            rvr_pkg::CSR_VOL_HEIGHT: dims_ff[1] <= csr_data[rvr_pkg::DIM_W-1:0];
            rvr_pkg::CSR_VOL_DEPTH:  dims_ff[2] <= csr_data[rvr_pkg::DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline advance
   assign en = !out_valid || rsp_chan.ready;
   assign req_chan.ready = en;

   always_comb begin
      item.valid  = req_chan.valid;
      item.sample = (req_chan.func == rvr_pkg::FUNC_SAMPLE);
      item.cx     = req_chan.coord_x;
      item.cy     = req_chan.coord_y;
      item.cz     = req_chan.coord_z;
      item.vin    = req_chan.voxel_in;
   end

   rvr_xform u_xform (
      .clock (clock), .reset (reset), .en (en),
      .item  (item), .rows (rows_ff), .tpos (tpos)
   );

   rvr_volume u_volume (
      .clock (clock), .reset (reset), .en (en),
      .tpos  (tpos), .dims (dims_ff), .rd (rd), .rdata (rdata)
   );

   rvr_blend u_blend (
      .clock     (clock), .reset (reset), .en (en),
      .rd        (rd), .rdata (rdata),
      .out_valid (out_valid), .out_voxel (out_voxel)
   );

   assign rsp_chan.valid     = out_valid;
   assign rsp_chan.voxel_out = out_voxel;

   // checks
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !out_valid)
      else $error("result valid right after reset");

   a_sample_to_read: assert property (@(posedge clock) disable iff (reset)
      en && tpos.valid && tpos.sample |=> rd.valid)
      else $error("sample lost at volume read");

   a_load_no_read: assert property (@(posedge clock) disable iff (reset)
      en && tpos.valid && !tpos.sample |=> !rd.valid)
      else $error("load produced a read");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> rd.valid == $past(rd.valid) && out_valid)
      else $error("pipeline moved during stall");

endmodule

@@ sim/tb_rigid_volume_resample_trilinear_top.sv @@
`timescale 1ns / 1ps

module tb_rigid_volume_resample_trilinear_top;

   localparam int COORD_W   = rvr_pkg::COORD_W;
   localparam int VOX_W     = rvr_pkg::VOX_W;
   localparam int ROW_W     = rvr_pkg::ROW_W;
   localparam int DIM_W     = rvr_pkg::DIM_W;
   localparam int CSR_IDX_W = rvr_pkg::CSR_IDX_W;
   localparam int STORE_SIZE = rvr_pkg::MAX_WIDTH * rvr_pkg::MAX_HEIGHT * rvr_pkg::MAX_DEPTH;
   localparam int DRAIN_CYCLES = 12;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [ROW_W-1:0] csr_data;

   rvr_req_if req_chan ();
   rvr_rsp_if rsp_chan ();

   rigid_volume_resample_trilinear_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan.sink),
      .rsp_chan  (rsp_chan.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // mirror of the volume and the registers
   logic [VOX_W-1:0] voxel_mirror [0:STORE_SIZE-1];
   bit voxel_written [0:STORE_SIZE-1];
   logic [ROW_W-1:0] mirror_row [0:2];
   logic [DIM_W-1:0] mirror_dim [0:2];

   logic [VOX_W-1:0] expected_voxels [$];
   int unsigned error_count;

   // idle control
   bit sender_calm;
   bit receiver_calm;
   bit hold_go;
   int hold_left;
   int stall_left;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic int store_addr(int x, int y, int z);
      return x + y * rvr_pkg::MAX_WIDTH + z * rvr_pkg::MAX_WIDTH * rvr_pkg::MAX_HEIGHT;
   endfunction

   // one mapped coordinate in Q.15
   function automatic longint map_axis(logic [ROW_W-1:0] r, longint px, longint py,
                                       longint pz);
      return longint'($signed(r[15:0])) * px + longint'($signed(r[31:16])) * py
           + longint'($signed(r[47:32])) * pz + longint'($signed(r[63:48])) * 1024;
   endfunction

   function automatic int clip_dim(logic [DIM_W-1:0] d, int maxv);
      return (int'(d) > maxv) ? maxv : int'(d);
   endfunction

   // trilinear resample of one output voxel; safe is low if an unloaded voxel is read
   function automatic void resample_point(input logic [COORD_W-1:0] x, y, z,
                                          output bit safe, output logic [VOX_W-1:0] res);
      longint t [0:2];
      longint base [0:2];
      int unsigned f [0:2];
      int lim [0:2];
      int unsigned c [0:7];
      int unsigned p00, p01, p10, p11, p0, p1, s;
      bit outside;
      for (int a = 0; a < 3; a++)
         t[a] = map_axis(mirror_row[a], 2 * longint'(x) + 1, 2 * longint'(y) + 1,
                         2 * longint'(z) + 1);
      lim[0] = clip_dim(mirror_dim[0], rvr_pkg::MAX_WIDTH);
      lim[1] = clip_dim(mirror_dim[1], rvr_pkg::MAX_HEIGHT);
      lim[2] = clip_dim(mirror_dim[2], rvr_pkg::MAX_DEPTH);
      outside = 1'b0;
      for (int a = 0; a < 3; a++) begin
         base[a] = t[a] >>> 15;
         f[a] = int'(t[a][14:7]);
         if (base[a] < 0 || base[a] + 1 >= lim[a]) outside = 1'b1;
      end
      safe = 1'b1;
      res = '0;
      if (outside) return;
      // corner k: bit0 x, bit1 y, bit2 z
      for (int k = 0; k < 8; k++) begin
         int ad;
         ad = store_addr(int'(base[0]) + int'(k[0]), int'(base[1]) + int'(k[1]),
                         int'(base[2]) + int'(k[2]));
         if (!voxel_written[ad]) safe = 1'b0;
         c[k] = voxel_mirror[ad];
      end
      p00 = c[0] * (256 - f[0]) + c[1] * f[0];
      p01 = c[4] * (256 - f[0]) + c[5] * f[0];
      p10 = c[2] * (256 - f[0]) + c[3] * f[0];
      p11 = c[6] * (256 - f[0]) + c[7] * f[0];
      p0 = p00 * (256 - f[1]) + p10 * f[1];
      p1 = p01 * (256 - f[1]) + p11 * f[1];
      s = p0 * (256 - f[2]) + p1 * f[2];
      res = 8'((s + 32'd8388608) >> 24);
   endfunction

   function automatic int pick_gap(bit calm);
      if (calm || $urandom_range(0, 3) != 0) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 30);
      return $urandom_range(1, 3);
   endfunction

   // send one item and record what it should produce
   task automatic send_item(logic f, logic [COORD_W-1:0] x, y, z, logic [VOX_W-1:0] v);
      int gap;
      bit safe;
      logic [VOX_W-1:0] res;
      gap = pick_gap(sender_calm);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.func <= f;
      req_chan.coord_x <= x;
      req_chan.coord_y <= y;
      req_chan.coord_z <= z;
      req_chan.voxel_in <= v;
      do @(negedge clock); while (!req_chan.ready);
      @(posedge clock);
      if (f == rvr_pkg::FUNC_SAMPLE) begin
         resample_point(x, y, z, safe, res);
         expected_voxels.push_back(res);
      end else begin
         voxel_mirror[store_addr(int'(x), int'(y), int'(z))] = v;
         voxel_written[store_addr(int'(x), int'(y), int'(z))] = 1'b1;
      end
   endtask

   task automatic stop_sending();
      req_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait until every result is back and the pipe has drained
   task automatic wait_idle();
      stop_sending();
      while (expected_voxels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write all registers; block must be idle
   task automatic program_regs(logic [ROW_W-1:0] rx, ry, rz, logic [DIM_W-1:0] w, h, d);
      logic [ROW_W-1:0] vals [0:5];
      logic [CSR_IDX_W-1:0] idx [0:5];
      vals = '{rx, ry, rz, ROW_W'(w), ROW_W'(h), ROW_W'(d)};
      idx = '{rvr_pkg::CSR_ROW_X, rvr_pkg::CSR_ROW_Y, rvr_pkg::CSR_ROW_Z,
              rvr_pkg::CSR_VOL_WIDTH, rvr_pkg::CSR_VOL_HEIGHT, rvr_pkg::CSR_VOL_DEPTH};
      for (int i = 0; i < 6; i++) begin
         csr_we <= 1'b1;
         csr_index <= idx[i];
         csr_data <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      mirror_row[0] = rx;
      mirror_row[1] = ry;
      mirror_row[2] = rz;
      mirror_dim[0] = w;
      mirror_dim[1] = h;
      mirror_dim[2] = d;
      @(posedge clock);
   endtask

   function automatic logic [ROW_W-1:0] pack_row(logic [15:0] cx, cy, cz, t);
      return {t, cz, cy, cx};
   endfunction

   // sample if it reads only loaded voxels, else load a random voxel in the cube
   task automatic send_safe_sample(logic [COORD_W-1:0] x, y, z);
      bit safe;
      logic [VOX_W-1:0] res;
      resample_point(x, y, z, safe, res);
      if (safe) send_item(rvr_pkg::FUNC_SAMPLE, x, y, z, VOX_W'($urandom));
      else send_item(rvr_pkg::FUNC_LOAD, COORD_W'($urandom_range(0, 7)),
                     COORD_W'($urandom_range(0, 7)), COORD_W'($urandom_range(0, 7)),
                     VOX_W'($urandom));
   endtask

   // receiver stalls
   always @(posedge clock) begin
      if (hold_go) begin
         hold_go = 1'b0;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
         if (!receiver_calm && $urandom_range(0, 3) == 0)
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 3);
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_voxels.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual voxel_out %0d",
                     $realtime, rsp_chan.voxel_out);
            error_count++;
         end else begin
            logic [VOX_W-1:0] want;
            want = expected_voxels.pop_front();
            if (rsp_chan.voxel_out !== want) begin
               $display("%0t: voxel_out mismatch, expected %0d, actual %0d",
                        $realtime, want, rsp_chan.voxel_out);
               error_count++;
            end
         end
      end
   end

   // fill a small cube and the top corner so samples have data
   task automatic test_fill();
      for (int z = 0; z < 8; z++)
         for (int y = 0; y < 8; y++)
            for (int x = 0; x < 8; x++)
               send_item(rvr_pkg::FUNC_LOAD, COORD_W'(x), COORD_W'(y), COORD_W'(z),
                         VOX_W'($urandom));
      for (int k = 0; k < 8; k++)
         send_item(rvr_pkg::FUNC_LOAD, COORD_W'(62 + int'(k[0])), COORD_W'(62 + int'(k[1])),
                   COORD_W'(62 + int'(k[2])), (k == 0) ? 8'hFF : 8'h00);
      send_item(rvr_pkg::FUNC_LOAD, 6'd0, 6'd0, 6'd0, 8'h00);
      send_item(rvr_pkg::FUNC_LOAD, 6'd1, 6'd1, 6'd1, 8'hFF);
   endtask

   // identity mapping at reset values: centers, edges and outside points
   task automatic test_directed_identity();
      send_safe_sample(6'd0, 6'd0, 6'd0);
      send_safe_sample(6'd3, 6'd5, 6'd6);
      send_safe_sample(6'd6, 6'd6, 6'd6);
      send_safe_sample(6'd62, 6'd62, 6'd62);
      send_safe_sample(6'd63, 6'd63, 6'd63);
      send_safe_sample(6'd63, 6'd0, 6'd0);
      send_safe_sample(6'd0, 6'd63, 6'd0);
      send_safe_sample(6'd0, 6'd0, 6'd63);
      send_safe_sample(6'd7, 6'd7, 6'd7);
   endtask

   // register extremes and degenerate sizes
   task automatic test_register_extremes();
      // half scale with quarter-voxel shift
      wait_idle();
      program_regs(pack_row(16'd8192, 16'd0, 16'd0, 16'd8),
                   pack_row(16'd0, 16'd8192, 16'd0, 16'd8),
                   pack_row(16'd0, 16'd0, 16'd8192, 16'd8), 7'd8, 7'd8, 7'd8);
      for (int i = 0; i < 8; i++)
         send_safe_sample(COORD_W'(i), COORD_W'(7 - i), COORD_W'(i / 2));
      // negative coefficients and translation at the far end
      wait_idle();
      program_regs(pack_row(16'h8000, 16'd0, 16'd0, 16'h7FFF),
                   pack_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000),
                   pack_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 7'd127, 7'd127, 7'd127);
      send_safe_sample(6'd0, 6'd0, 6'd0);
      send_safe_sample(6'd63, 6'd63, 6'd63);
      send_safe_sample(6'd21, 6'd42, 6'd5);
      // zero and one-voxel sizes make every sample outside
      wait_idle();
      program_regs(rvr_pkg::ROW_X_RST, rvr_pkg::ROW_Y_RST, rvr_pkg::ROW_Z_RST,
                   7'd0, 7'd64, 7'd64);
      send_safe_sample(6'd1, 6'd1, 6'd1);
      wait_idle();
      program_regs(rvr_pkg::ROW_X_RST, rvr_pkg::ROW_Y_RST, rvr_pkg::ROW_Z_RST,
                   7'd1, 7'd1, 7'd1);
      send_safe_sample(6'd0, 6'd0, 6'd0);
      // smallest inside size
      wait_idle();
      program_regs(rvr_pkg::ROW_X_RST, rvr_pkg::ROW_Y_RST, rvr_pkg::ROW_Z_RST,
                   7'd2, 7'd2, 7'd2);
      send_safe_sample(6'd0, 6'd0, 6'd0);
      send_safe_sample(6'd1, 6'd0, 6'd0);
   endtask

   task automatic random_config();
      logic [15:0] co [0:2][0:3];
      wait_idle();
      if ($urandom_range(0, 5) == 0) begin
         program_regs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                      DIM_W'($urandom), DIM_W'($urandom), DIM_W'($urandom));
         return;
      end
      // shrinking map into the loaded cube, mildly rotated
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++)
            co[r][c] = (r == c) ? 16'($urandom_range(1500, 2200))
                                : 16'(int'($urandom_range(0, 400)) - 200);
         co[r][3] = 16'($urandom_range(0, 40));
      end
      program_regs(pack_row(co[0][0], co[0][1], co[0][2], co[0][3]),
                   pack_row(co[1][0], co[1][1], co[1][2], co[1][3]),
                   pack_row(co[2][0], co[2][1], co[2][2], co[2][3]),
                   DIM_W'($urandom_range(2, 10)), DIM_W'($urandom_range(2, 10)),
                   DIM_W'($urandom_range(2, 10)));
   endtask

   // random mix; configuration changes between bursts
   task automatic test_random_mix(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0) begin
            random_config();
            sender_calm = ($urandom_range(0, 3) == 0);
            receiver_calm = ($urandom_range(0, 3) == 0);
         end
         case ($urandom_range(0, 9))
            0: send_item(rvr_pkg::FUNC_LOAD, COORD_W'($urandom), COORD_W'($urandom),
                         COORD_W'($urandom), VOX_W'($urandom));
            1: send_item(rvr_pkg::FUNC_LOAD, COORD_W'($urandom_range(0, 7)),
                         COORD_W'($urandom_range(0, 7)), COORD_W'($urandom_range(0, 7)),
                         VOX_W'($urandom));
            default: begin
               bit safe;
               logic [VOX_W-1:0] res;
               logic [COORD_W-1:0] x, y, z;
               safe = 1'b0;
               for (int t = 0; t < 8 && !safe; t++) begin
                  x = COORD_W'($urandom);
                  y = COORD_W'($urandom);
                  z = COORD_W'($urandom);
                  resample_point(x, y, z, safe, res);
               end
               send_safe_sample(x, y, z);
            end
         endcase
      end
   endtask

   // receiver holds off while samples keep coming
   task automatic test_backpressure();
      wait_idle();
      program_regs(pack_row(16'd2048, 16'd0, 16'd0, 16'd0),
                   pack_row(16'd0, 16'd2048, 16'd0, 16'd0),
                   pack_row(16'd0, 16'd0, 16'd2048, 16'd0), 7'd64, 7'd64, 7'd64);
      sender_calm = 1'b1;
      hold_go = 1'b1;
      for (int i = 0; i < 40; i++)
         send_safe_sample(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
      sender_calm = 1'b0;
      wait_idle();
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_chan.valid = 1'b0;
      req_chan.func = rvr_pkg::FUNC_LOAD;
      req_chan.coord_x = '0;
      req_chan.coord_y = '0;
      req_chan.coord_z = '0;
      req_chan.voxel_in = '0;
      rsp_chan.ready = 1'b0;
      error_count = 0;
      sender_calm = 1'b0;
      receiver_calm = 1'b0;
      hold_go = 1'b0;
      hold_left = 0;
      stall_left = 0;
      for (int i = 0; i < STORE_SIZE; i++) begin
         voxel_mirror[i] = '0;
         voxel_written[i] = 1'b0;
      end
      mirror_row[0] = rvr_pkg::ROW_X_RST;
      mirror_row[1] = rvr_pkg::ROW_Y_RST;
      mirror_row[2] = rvr_pkg::ROW_Z_RST;
      for (int a = 0; a < 3; a++) mirror_dim[a] = rvr_pkg::DIM_RST;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_fill();
      test_directed_identity();
      test_register_extremes();
      test_backpressure();
      test_random_mix(120);

      wait_idle();
      if (error_count == 0 && expected_voxels.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
